// ===== rtl/core/ocs_pkg.sv =====
// Shared types and codes for the overwriting circular stack.
// No dependencies; the interfaces and the core use these by scoped names.
`default_nettype none

package ocs_pkg;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_CONTAINS = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 7;

    localparam logic [CFG_ADDR_W-1:0] ADDR_STACK_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0]     SIZE_RESET      = 7'd64;
    localparam logic [SIZE_W-1:0]     SIZE_MIN        = 7'd2;

endpackage

`default_nettype wire

// ===== rtl/core/ocs_if.sv =====
// Valid/ready channel interfaces for command and response beats.
// Depends on ocs_pkg for the action and status types.
`default_nettype none

interface ocs_cmd_if #(
    parameter int WORD_WIDTH = 16
) ();
    logic                    valid;
    logic                    ready;
    ocs_pkg::action_t        action;
    logic [WORD_WIDTH-1:0]   push_data;

    modport source (output valid, output action, output push_data, input ready);
    modport sink   (input valid, input action, input push_data, output ready);
endinterface

interface ocs_rsp_if #(
    parameter int WORD_WIDTH = 16
) ();
    logic                    valid;
    logic                    ready;
    logic [WORD_WIDTH-1:0]   pop_data;
    logic                    pop_valid;
    ocs_pkg::status_t        status;

    modport source (output valid, output pop_data, output pop_valid, output status, input ready);
    modport sink   (input valid, input pop_data, input pop_valid, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/overwriting_circular_stack_core.sv =====
// Overwriting circular LIFO stack core: store, index and count logic, APB size register.
// Depends on ocs_pkg and on the ocs_cmd_if / ocs_rsp_if interfaces.
//
//   channel | dir | handshake      | payload
//   cmd     | in  | valid/ready    | action, push_data
//   rsp     | out | valid/ready    | pop_data, pop_valid, status
//   apb     | in  | psel/penable   | paddr, pwdata -> stack_size
//
// One command beat per cycle while the response side keeps up; the response is registered at acceptance.
// Index, count and store write update at acceptance; the store read lands in the
// response register, so the store port and one index step set the one-per-cycle rate.
// Reset empties the stack at once (count zero); store contents stay undefined.
// A stalled response holds and blocks the next command until it is taken.
`default_nettype none

module overwriting_circular_stack_core #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ocs_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [ocs_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [ocs_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                     pready,
    ocs_cmd_if.sink                                  cmd,
    ocs_rsp_if.source                                rsp
);

    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int RST_USED = (DEPTH < 64) ? DEPTH : 64;

    logic [WORD_WIDTH-1:0]     mem [DEPTH];

    logic [ocs_pkg::SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]          used_reg;
    logic [CNT_W-1:0]          used_next;
    logic [IDX_W-1:0]          top_reg;
    logic [IDX_W-1:0]          top_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    logic                      pop_valid_reg;
    logic                      pop_valid_next;
    ocs_pkg::status_t          status_reg;
    ocs_pkg::status_t          status_next;
    logic [WORD_WIDTH-1:0]     rd_data_reg;

    logic                      cfg_wr;
    logic                      accept;
    logic                      do_push;
    logic                      do_pop;
    logic [ocs_pkg::SIZE_W-1:0] wr_size;

    assign pready = 1'b1;
    assign prdata = (paddr == ocs_pkg::ADDR_STACK_SIZE)
                  ? {{(ocs_pkg::CFG_DATA_W - ocs_pkg::SIZE_W){1'b0}}, size_reg}
                  : '0;

    assign cfg_wr  = psel && penable && pwrite && pready
                  && (paddr == ocs_pkg::ADDR_STACK_SIZE);
    assign wr_size = pwdata[ocs_pkg::SIZE_W-1:0];

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign do_push   = accept && (cmd.action == ocs_pkg::ACT_PUSH);
    assign do_pop    = accept && (cmd.action == ocs_pkg::ACT_POP) && (count_reg != '0);

    always_comb
    begin
        priority if (32'(wr_size) > 32'(DEPTH))
        begin
            used_next = CNT_W'(DEPTH);
        end
        else if (wr_size < ocs_pkg::SIZE_MIN)
        begin
            used_next = CNT_W'(ocs_pkg::SIZE_MIN);
        end
        else
        begin
            used_next = CNT_W'(wr_size);
        end
    end

    always_comb
    begin
        top_next       = top_reg;
        count_next     = count_reg;
        pop_valid_next = 1'b0;
        if (do_push)
        begin
            top_next = ((CNT_W'(top_reg) + CNT_W'(1)) >= used_reg)
                     ? '0 : top_reg + IDX_W'(1);
            count_next = (count_reg >= used_reg - CNT_W'(1))
                       ? used_reg : count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            top_next       = (top_reg == '0) ? IDX_W'(used_reg - CNT_W'(1))
                                             : top_reg - IDX_W'(1);
            count_next     = count_reg - CNT_W'(1);
            pop_valid_next = 1'b1;
        end
        priority if (count_next == '0)
        begin
            status_next = ocs_pkg::ST_EMPTY;
        end
        else if (count_next == used_reg)
        begin
            status_next = ocs_pkg::ST_FULL;
        end
        else
        begin
            status_next = ocs_pkg::ST_CONTAINS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= ocs_pkg::SIZE_RESET;
            used_reg      <= CNT_W'(RST_USED);
            top_reg       <= IDX_W'(RST_USED - 1);
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            pop_valid_reg <= 1'b0;
            status_reg    <= ocs_pkg::ST_EMPTY;
        end
        else
        begin
            if (cfg_wr)
            begin
                size_reg  <= wr_size;
                used_reg  <= used_next;
                top_reg   <= IDX_W'(used_next - CNT_W'(1));
                count_reg <= '0;
            end
            else if (accept)
            begin
                top_reg   <= top_next;
                count_reg <= count_next;
            end

            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
                pop_valid_reg <= pop_valid_next;
                status_reg    <= status_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Write the pushed word at the advanced top; read the current top on pop.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[top_next] <= cmd.push_data;
        end
        if (accept)
        begin
            rd_data_reg <= do_pop ? mem[top_reg] : '0;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.pop_data  = rd_data_reg;
    assign rsp.pop_valid = pop_valid_reg;
    assign rsp.status    = status_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= used_reg)
        else $error("entry count exceeds size in use");

    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(top_reg) < used_reg)
        else $error("top index outside size in use");

    a_push_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> rsp_valid_reg && !pop_valid_reg && (status_reg != ocs_pkg::ST_EMPTY))
        else $error("push response reports popped data or empty");

    a_status_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_wr |=> ((status_reg == ocs_pkg::ST_EMPTY) == (count_reg == '0))
                          && ((status_reg == ocs_pkg::ST_FULL) == (count_reg == used_reg)))
        else $error("status does not match entry count");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> count_reg == '0)
        else $error("size write did not empty the stack");

endmodule

`default_nettype wire
